[design/dbd_pkg.sv]
// shared types and constants for the detector box decode block
// no dependencies; imported by every module of the block
package dbd_pkg;

	localparam int SCORE_W   = 16;
	localparam int CLASS_W   = 8;
	localparam int COORD_W   = 15;
	localparam int PIX_W     = 12;
	localparam int SCALE_W   = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;
	// 2*c +/- s - 2*pad in 1/32 pixel
	localparam int DIFF_W    = COORD_W + 3;
	// fractional bits of the product: 5 from 1/32 pixel, 16 from q4.16
	localparam int FRAC_W    = 21;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLASS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_X           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_Y           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd6;

	localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
	localparam logic [SCALE_W-1:0] RST_INV_SCALE       = 20'd65536;
	localparam logic [PIX_W-1:0]   RST_IMAGE_SIZE      = 12'd640;

	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		logic               have;
		logic [SCORE_W-1:0] score;
		logic [CLASS_W-1:0] cls;
	} best_t;

endpackage

[design/dbd_best.sv]
// running best score and class over the class scores of one box
// depends on dbd_pkg
module dbd_best #(
	parameter int MAX_CLASSES = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [dbd_pkg::SCORE_W-1:0] score,
	input  logic                    last,
	output dbd_pkg::best_t          best_next
);
	import dbd_pkg::*;

	localparam int CNT_W = $clog2(MAX_CLASSES + 1);

	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W+CLASS_W-1:0] cnt_ext;
	best_t                  best_q;
	logic                   in_range;
	logic                   better;

	assign cnt_ext  = {{CLASS_W{1'b0}}, cnt_q};
	assign in_range = cnt_q < CNT_W'(MAX_CLASSES);
	assign better   = in_range && (score > best_q.score);

	always_comb begin
		best_next = best_q;
		if (better) begin
			best_next.have  = 1'b1;
			best_next.score = score;
			best_next.cls   = cnt_ext[CLASS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			best_q <= '0;
		end else if (advance) begin
			if (last) begin
				cnt_q  <= '0;
				best_q <= '0;
			end else begin
				best_q <= best_next;
				// counter saturates once every class slot is used
				if (in_range)
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

[design/dbd_corner.sv]
// one box corner: scale a padded offset to image pixels and clamp
// depends on dbd_pkg
module dbd_corner (
	input  dbd_pkg::diff_t                diff,
	input  logic [dbd_pkg::SCALE_W-1:0] inv_scale,
	input  logic [dbd_pkg::PIX_W-1:0]   limit,
	output logic [dbd_pkg::PIX_W-1:0]   pixel
);
	import dbd_pkg::*;

	localparam int PROD_W = DIFF_W + SCALE_W + 1;
	localparam int INT_W  = PROD_W - 1 - FRAC_W;

	logic signed [PROD_W-1:0] prod;
	logic signed [SCALE_W:0]  scale_s;
	logic [INT_W-1:0]         whole;
	logic                     positive;

	assign scale_s  = $signed({1'b0, inv_scale});
	assign prod     = diff * scale_s;
	assign whole    = prod[PROD_W-2:FRAC_W];
	assign positive = !prod[PROD_W-1] && (prod != '0);

	always_comb begin
		if (!positive)
			pixel = '0;
		else if (whole >= INT_W'(limit))
			pixel = limit;
		else
			pixel = whole[PIX_W-1:0];
	end

endmodule

[design/detector_box_decode_core.sv]
// detector box decode: best-class search per box and letterbox corner mapping
// depends on dbd_pkg, dbd_best, dbd_corner
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  in      | in_valid  | in_stall  | class_score last_class center_x/y box_width/height
//  out     | out_valid | out_stall | keep left top right bottom best_score/class_out
//  cfg     | cfg_we    | -         | cfg_index cfg_data
//
// one item is taken every cycle while in_stall is low; a result passes the input, stage 2 and result registers
// stages: input register, best update and offsets, multiply and clamp into output
// in_stall follows out_stall while a result is held; the whole pipe freezes together
// reset clears valid bits and box state and sets the config registers to their reset values
module detector_box_decode_core #(
	parameter int MAX_CLASSES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbd_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dbd_pkg::SCORE_W-1:0]        class_score,
	input  logic                               last_class,
	input  logic signed [dbd_pkg::COORD_W-1:0] center_x,
	input  logic signed [dbd_pkg::COORD_W-1:0] center_y,
	input  logic signed [dbd_pkg::COORD_W-1:0] box_width,
	input  logic signed [dbd_pkg::COORD_W-1:0] box_height,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               keep,
	output logic [dbd_pkg::PIX_W-1:0]          left,
	output logic [dbd_pkg::PIX_W-1:0]          top,
	output logic [dbd_pkg::PIX_W-1:0]          right,
	output logic [dbd_pkg::PIX_W-1:0]          bottom,
	output logic [dbd_pkg::SCORE_W-1:0]        best_score_out,
	output logic [dbd_pkg::CLASS_W-1:0]        best_class_out
);
	import dbd_pkg::*;

	// configuration
	logic [SCORE_W-1:0]        thr_q;
	logic [CLASS_W-1:0]        tgt_q;
	logic signed [COORD_W-1:0] pad_x_q;
	logic signed [COORD_W-1:0] pad_y_q;
	logic [SCALE_W-1:0]        inv_scale_q;
	logic [PIX_W-1:0]          img_w_q;
	logic [PIX_W-1:0]          img_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= RST_SCORE_THRESHOLD;
			tgt_q       <= '0;
			pad_x_q     <= '0;
			pad_y_q     <= '0;
			inv_scale_q <= RST_INV_SCALE;
			img_w_q     <= RST_IMAGE_SIZE;
			img_h_q     <= RST_IMAGE_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THRESHOLD: thr_q       <= cfg_data[SCORE_W-1:0];
				REG_TARGET_CLASS:    tgt_q       <= cfg_data[CLASS_W-1:0];
				REG_PAD_X:           pad_x_q     <= $signed(cfg_data[COORD_W-1:0]);
				REG_PAD_Y:           pad_y_q     <= $signed(cfg_data[COORD_W-1:0]);
				REG_INV_SCALE:       inv_scale_q <= cfg_data[SCALE_W-1:0];
				REG_IMAGE_WIDTH:     img_w_q     <= cfg_data[PIX_W-1:0];
				REG_IMAGE_HEIGHT:    img_h_q     <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	logic advance;
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	// stage 1: input register
	logic                      valid_s1;
	logic [SCORE_W-1:0]        score_s1;
	logic                      last_s1;
	logic signed [COORD_W-1:0] cx_s1;
	logic signed [COORD_W-1:0] cy_s1;
	logic signed [COORD_W-1:0] bw_s1;
	logic signed [COORD_W-1:0] bh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			score_s1 <= class_score;
			last_s1  <= last_class;
			cx_s1    <= center_x;
			cy_s1    <= center_y;
			bw_s1    <= box_width;
			bh_s1    <= box_height;
		end
	end

	best_t best_next;

	dbd_best #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance && valid_s1),
		.score    (score_s1),
		.last     (last_s1),
		.best_next(best_next)
	);

	diff_t cx2, cy2, px2, py2;
	diff_t d_left, d_top, d_right, d_bottom;

	assign cx2      = DIFF_W'(cx_s1) <<< 1;
	assign cy2      = DIFF_W'(cy_s1) <<< 1;
	assign px2      = DIFF_W'(pad_x_q) <<< 1;
	assign py2      = DIFF_W'(pad_y_q) <<< 1;
	assign d_left   = cx2 - DIFF_W'(bw_s1) - px2;
	assign d_right  = cx2 + DIFF_W'(bw_s1) - px2;
	assign d_top    = cy2 - DIFF_W'(bh_s1) - py2;
	assign d_bottom = cy2 + DIFF_W'(bh_s1) - py2;

	// stage 2: box summary and offsets of a finished box
	logic               valid_s2;
	logic               keep_s2;
	logic [SCORE_W-1:0] score_s2;
	logic [CLASS_W-1:0] class_s2;
	diff_t              d_left_s2, d_top_s2, d_right_s2, d_bottom_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1 && last_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			keep_s2     <= best_next.have && (best_next.score >= thr_q) &&
			               (best_next.cls == tgt_q);
			score_s2    <= best_next.have ? best_next.score : '0;
			class_s2    <= best_next.have ? best_next.cls : '0;
			d_left_s2   <= d_left;
			d_top_s2    <= d_top;
			d_right_s2  <= d_right;
			d_bottom_s2 <= d_bottom;
		end
	end

	logic [PIX_W-1:0] px_left, px_top, px_right, px_bottom;

	dbd_corner u_left (
		.diff(d_left_s2), .inv_scale(inv_scale_q), .limit(img_w_q), .pixel(px_left)
	);
	dbd_corner u_top (
		.diff(d_top_s2), .inv_scale(inv_scale_q), .limit(img_h_q), .pixel(px_top)
	);
	dbd_corner u_right (
		.diff(d_right_s2), .inv_scale(inv_scale_q), .limit(img_w_q), .pixel(px_right)
	);
	dbd_corner u_bottom (
		.diff(d_bottom_s2), .inv_scale(inv_scale_q), .limit(img_h_q), .pixel(px_bottom)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance)
			out_valid <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			keep           <= keep_s2;
			left           <= px_left;
			top            <= px_top;
			right          <= px_right;
			bottom         <= px_bottom;
			best_score_out <= score_s2;
			best_class_out <= class_s2;
		end
	end

endmodule

[tb/box_decode_checker.sv]
// box decode checker: watches the config port and both item channels,
// predicts each box result and compares it field by field; depends on dbd_pkg
`timescale 1ns / 1ps

module box_decode_checker #(
	parameter int MAX_CLASSES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbd_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [dbd_pkg::SCORE_W-1:0]        class_score,
	input  logic                               last_class,
	input  logic signed [dbd_pkg::COORD_W-1:0] center_x,
	input  logic signed [dbd_pkg::COORD_W-1:0] center_y,
	input  logic signed [dbd_pkg::COORD_W-1:0] box_width,
	input  logic signed [dbd_pkg::COORD_W-1:0] box_height,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               keep,
	input  logic [dbd_pkg::PIX_W-1:0]          left,
	input  logic [dbd_pkg::PIX_W-1:0]          top,
	input  logic [dbd_pkg::PIX_W-1:0]          right,
	input  logic [dbd_pkg::PIX_W-1:0]          bottom,
	input  logic [dbd_pkg::SCORE_W-1:0]        best_score_out,
	input  logic [dbd_pkg::CLASS_W-1:0]        best_class_out,
	output int                                 fail_count,
	output int                                 pending
);
	import dbd_pkg::*;

	typedef struct packed {
		logic               keep;
		logic [PIX_W-1:0]   left;
		logic [PIX_W-1:0]   top;
		logic [PIX_W-1:0]   right;
		logic [PIX_W-1:0]   bottom;
		logic [SCORE_W-1:0] score;
		logic [CLASS_W-1:0] cls;
	} box_result_t;

	// register copies
	logic [SCORE_W-1:0]        thr;
	logic [CLASS_W-1:0]        tgt;
	logic signed [COORD_W-1:0] pad_x;
	logic signed [COORD_W-1:0] pad_y;
	logic [SCALE_W-1:0]        scale;
	logic [PIX_W-1:0]          img_w;
	logic [PIX_W-1:0]          img_h;

	// open box
	best_t      run;
	logic [8:0] seen;

	box_result_t box_q[$];

	// d in 1/32 pixel, product in 2^-21 pixel, clamped to [0, limit]
	function automatic logic [PIX_W-1:0] to_pixel(diff_t d, logic [SCALE_W-1:0] sc,
		logic [PIX_W-1:0] limit);
		longint prod;
		longint whole;
		prod = longint'(d) * longint'(sc);
		if (prod <= 0)
			return '0;
		whole = prod >>> FRAC_W;
		if (whole >= longint'(limit))
			return limit;
		return whole[PIX_W-1:0];
	endfunction

	function automatic bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		box_result_t want;
		diff_t       d_l, d_t, d_r, d_b;
		int          errs;
		bit          bad;
		if (!arst_n) begin
			thr   = RST_SCORE_THRESHOLD;
			tgt   = '0;
			pad_x = '0;
			pad_y = '0;
			scale = RST_INV_SCALE;
			img_w = RST_IMAGE_SIZE;
			img_h = RST_IMAGE_SIZE;
			run   = '0;
			seen  = '0;
			box_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SCORE_THRESHOLD: thr   = cfg_data[SCORE_W-1:0];
					REG_TARGET_CLASS:    tgt   = cfg_data[CLASS_W-1:0];
					REG_PAD_X:           pad_x = cfg_data[COORD_W-1:0];
					REG_PAD_Y:           pad_y = cfg_data[COORD_W-1:0];
					REG_INV_SCALE:       scale = cfg_data[SCALE_W-1:0];
					REG_IMAGE_WIDTH:     img_w = cfg_data[PIX_W-1:0];
					REG_IMAGE_HEIGHT:    img_h = cfg_data[PIX_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (box_q.size() == 0) begin
					$error("box result with no box waiting");
					errs++;
				end else begin
					want = box_q.pop_front();
					bad = !field_ok("keep", want.keep, keep) |
						!field_ok("left", want.left, left) |
						!field_ok("top", want.top, top) |
						!field_ok("right", want.right, right) |
						!field_ok("bottom", want.bottom, bottom) |
						!field_ok("best_score_out", want.score, best_score_out) |
						!field_ok("best_class_out", want.cls, best_class_out);
					if (bad)
						errs++;
				end
			end

			if (in_valid && !in_stall) begin
				// scores past the class limit are dropped, the counter saturates
				if (seen < MAX_CLASSES) begin
					if (class_score > run.score) begin
						run.score = class_score;
						run.cls   = seen[CLASS_W-1:0];
						run.have  = 1'b1;
					end
					seen++;
				end
				if (last_class) begin
					d_l = DIFF_W'(2 * center_x - box_width - 2 * pad_x);
					d_r = DIFF_W'(2 * center_x + box_width - 2 * pad_x);
					d_t = DIFF_W'(2 * center_y - box_height - 2 * pad_y);
					d_b = DIFF_W'(2 * center_y + box_height - 2 * pad_y);
					want.keep   = run.have && run.score >= thr && run.cls == tgt;
					want.left   = to_pixel(d_l, scale, img_w);
					want.right  = to_pixel(d_r, scale, img_w);
					want.top    = to_pixel(d_t, scale, img_h);
					want.bottom = to_pixel(d_b, scale, img_h);
					want.score  = run.have ? run.score : '0;
					want.cls    = run.have ? run.cls : '0;
					box_q.insert(box_q.size(), want);
					run  = '0;
					seen = '0;
				end
			end

			pending    <= box_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

[tb/tb_top.sv]
// top of the box decode testbench: clock, reset, config writes, box streams
// and receiver stalls; depends on dbd_pkg, detector_box_decode_core, box_decode_checker
`timescale 1ns / 1ps

module tb_top;
	import dbd_pkg::*;

	localparam int N_CLASSES = 256;
	// no register sits at this index
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DAT_W-1:0]      cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [SCORE_W-1:0]        class_score;
	logic                      last_class;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic signed [COORD_W-1:0] box_width;
	logic signed [COORD_W-1:0] box_height;
	logic                      out_valid;
	logic                      out_stall;
	logic                      keep;
	logic [PIX_W-1:0]          left;
	logic [PIX_W-1:0]          top;
	logic [PIX_W-1:0]          right;
	logic [PIX_W-1:0]          bottom;
	logic [SCORE_W-1:0]        best_score_out;
	logic [CLASS_W-1:0]        best_class_out;
	int                        fail_count;
	int                        pending;

	int           items_sent;
	int           burst_left;
	bit           no_gaps;
	bit           offering;
	logic         squeeze_req;
	logic [7:0]   cur_target;

	always #5 clk = ~clk;

	detector_box_decode_core #(.MAX_CLASSES(N_CLASSES)) u_dut (.*);

	box_decode_checker #(.MAX_CLASSES(N_CLASSES)) u_check (.*);

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: changing stall pattern, plus one long hold-off on request
	initial begin
		int   hold;
		int   mode;
		int   mode_left;
		int   tick;
		bit   squeezed;
		logic st;
		hold      = 0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		squeezed  = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(30, 200);
			end
			mode_left--;
			if (squeeze_req && !squeezed) begin
				squeezed = 1;
				hold     = 80;
			end
			if (hold > 0) begin
				st = 1'b1;
				hold--;
			end else begin
				case (mode)
					0: st = 1'b0;
					1: st = ($urandom_range(0, 3) == 0);
					2: st = ($urandom_range(0, 3) != 0);
					default: st = (tick % 5 < 2);
				endcase
			end
			out_stall <= st;
		end
	end

	function automatic logic [CFG_DAT_W-1:0] widen(int value, int width);
		logic [CFG_DAT_W-1:0] mask;
		logic [CFG_DAT_W-1:0] r;
		mask = CFG_DAT_W'((64'd1 << width) - 1);
		r = ($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom) : '0;
		return (r & ~mask) | (CFG_DAT_W'(value) & mask);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic cfg_random();
		logic [SCORE_W-1:0]   thr;
		logic [CLASS_W-1:0]   tgt;
		logic [COORD_W-1:0]   px, py;
		logic [SCALE_W-1:0]   sc;
		logic [PIX_W-1:0]     w, h;
		case ($urandom_range(0, 5))
			0: thr = '0;
			1: thr = '1;
			default: thr = SCORE_W'($urandom_range(0, 40000));
		endcase
		tgt = ($urandom_range(0, 4) != 0) ? CLASS_W'($urandom_range(0, 7)) :
			CLASS_W'($urandom_range(0, 255));
		px = ($urandom_range(0, 3) != 0) ? COORD_W'(int'($urandom_range(0, 1000)) - 500) :
			COORD_W'($urandom);
		py = ($urandom_range(0, 3) != 0) ? COORD_W'(int'($urandom_range(0, 1000)) - 500) :
			COORD_W'($urandom);
		case ($urandom_range(0, 7))
			0: sc = '0;
			1: sc = '1;
			2, 3: sc = SCALE_W'($urandom);
			default: sc = SCALE_W'($urandom_range(40000, 140000));
		endcase
		w = ($urandom_range(0, 3) != 0) ? PIX_W'($urandom_range(100, 2000)) : PIX_W'($urandom);
		h = ($urandom_range(0, 3) != 0) ? PIX_W'($urandom_range(100, 2000)) : PIX_W'($urandom);
		cfg_write(REG_SCORE_THRESHOLD, widen(thr, SCORE_W));
		cfg_write(REG_TARGET_CLASS, widen(tgt, CLASS_W));
		cfg_write(REG_PAD_X, widen(px, COORD_W));
		cfg_write(REG_PAD_Y, widen(py, COORD_W));
		cfg_write(REG_INV_SCALE, widen(sc, SCALE_W));
		cfg_write(REG_IMAGE_WIDTH, widen(w, PIX_W));
		cfg_write(REG_IMAGE_HEIGHT, widen(h, PIX_W));
		cfg_we <= 1'b0;
		cur_target = tgt;
	endtask

	task automatic send_item(input logic [SCORE_W-1:0] s, input logic l,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
		int gap;
		in_valid    <= 1'b1;
		offering    = 1;
		class_score <= s;
		last_class  <= l;
		center_x    <= x;
		center_y    <= y;
		box_width   <= w;
		box_height  <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (no_gaps) begin
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			offering = 0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// one box of n scores; coordinates are random noise except on the last item
	task automatic send_box(input int n, input bit full_coords);
		int                 hot;
		int                 mode;
		int                 i;
		logic [SCORE_W-1:0] s;
		logic [SCORE_W-1:0] tie;
		logic [COORD_W-1:0] x, y, w, h;
		mode = $urandom_range(0, 3);
		hot  = (cur_target < n && $urandom_range(0, 1)) ? int'(cur_target) :
			int'($urandom_range(0, n - 1));
		tie  = SCORE_W'($urandom);
		if (full_coords) begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
			w = COORD_W'($urandom);
			h = COORD_W'($urandom);
		end else begin
			x = COORD_W'($urandom_range(0, 12000));
			y = COORD_W'($urandom_range(0, 12000));
			w = COORD_W'($urandom_range(0, 4000));
			h = COORD_W'($urandom_range(0, 4000));
		end
		for (i = 0; i < n; i++) begin
			case (mode)
				0: s = SCORE_W'($urandom);
				1: s = ($urandom_range(0, 4) == 0) ? SCORE_W'($urandom) : '0;
				2: s = tie;
				default: s = (i == hot) ? SCORE_W'($urandom_range(16384, 65535)) :
					SCORE_W'($urandom_range(0, 16383));
			endcase
			if (i == n - 1)
				send_item(s, 1'b1, x, y, w, h);
			else
				send_item(s, 1'b0, COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom));
		end
	endtask

	// stop offering and let every box result come back
	task automatic drain();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 0;
		end
		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int i;
		int n;
		int r;
		int phase;
		int quota;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		class_score <= '0;
		last_class  <= 1'b0;
		center_x    <= '0;
		center_y    <= '0;
		box_width   <= '0;
		box_height  <= '0;
		squeeze_req <= 1'b0;
		items_sent  = 0;
		burst_left  = 0;
		no_gaps     = 0;
		offering    = 0;
		cur_target  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: nothing above zero, threshold edges, ties, late best
		send_item(16'd0, 1'b1, 15'd0, 15'd0, 15'd0, 15'd0);
		send_item(16'd16384, 1'b1, 15'h3FFF, 15'h3FFF, 15'h4000, 15'h4000);
		send_item(16'd16383, 1'b1, 15'h4000, 15'h4000, 15'h3FFF, 15'h3FFF);
		send_item(16'd700, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0);
		send_item(16'd700, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0);
		send_item(16'd699, 1'b1, 15'd5000, 15'd3000, 15'd1600, 15'd800);
		send_item(16'd0, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0);
		send_item(16'd0, 1'b1, 15'd4000, 15'd4000, 15'd100, 15'd100);
		send_item(16'd1, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0);
		send_item(16'd65535, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0);
		send_item(16'd65535, 1'b1, 15'd2000, 15'd9000, 15'd700, 15'd300);
		drain();

		// zero threshold, largest scale, one-pixel width, extreme padding
		cfg_write(REG_SCORE_THRESHOLD, 20'd0);
		cfg_write(REG_PAD_X, 20'h04000);
		cfg_write(REG_PAD_Y, 20'h03FFF);
		cfg_write(REG_INV_SCALE, 20'hFFFFF);
		cfg_write(REG_IMAGE_WIDTH, 20'd1);
		cfg_write(REG_IMAGE_HEIGHT, 20'd4095);
		cfg_we <= 1'b0;
		send_item(16'd0, 1'b1, 15'd100, 15'd100, 15'd50, 15'd50);
		send_item(16'd1, 1'b1, 15'd100, 15'd100, 15'd50, 15'd50);
		send_item(16'd65535, 1'b1, 15'h4000, 15'h3FFF, 15'd0, 15'd0);
		drain();

		// top threshold, top class, zero scale, junk above the register widths
		cfg_write(REG_SCORE_THRESHOLD, 20'hFFFFF);
		cfg_write(REG_TARGET_CLASS, 20'hFFFFF);
		cfg_write(REG_PAD_X, 20'hF3FFF);
		cfg_write(REG_PAD_Y, 20'h0C000);
		cfg_write(REG_INV_SCALE, 20'd0);
		cfg_write(REG_IMAGE_WIDTH, 20'h0FFF);
		cfg_write(REG_IMAGE_HEIGHT, 20'd1);
		cfg_write(REG_SPARE, 20'hABCDE);
		cfg_we <= 1'b0;
		cur_target = 8'd255;
		send_item(16'd65535, 1'b1, 15'h3FFF, 15'h3FFF, 15'h3FFF, 15'h3FFF);
		drain();

		// full class range, then past it: late scores must be dropped
		cfg_write(REG_PAD_X, 20'd0);
		cfg_write(REG_PAD_Y, 20'd0);
		cfg_write(REG_INV_SCALE, 20'd65536);
		cfg_write(REG_IMAGE_HEIGHT, 20'd4095);
		cfg_we <= 1'b0;
		for (i = 0; i < N_CLASSES; i++)
			send_item((i == N_CLASSES - 1) ? 16'd65535 : 16'd65534, i == N_CLASSES - 1,
				15'd6000, 15'd7000, 15'd2000, 15'd3000);
		for (i = 0; i < 300; i++)
			send_item((i >= N_CLASSES) ? 16'd65535 : 16'($urandom_range(0, 60000)), i == 299,
				COORD_W'($urandom), COORD_W'($urandom),
				COORD_W'($urandom), COORD_W'($urandom));
		drain();

		// zero image size: width from junk-only data, height zero
		cfg_write(REG_IMAGE_WIDTH, 20'h01000);
		cfg_write(REG_IMAGE_HEIGHT, 20'd0);
		cfg_we <= 1'b0;
		send_box(3, 1'b0);
		send_box(2, 1'b1);
		drain();

		phase = 0;
		while (items_sent < 1250) begin
			cfg_random();
			if (phase == 2) begin
				// back-to-back boxes against a long receiver hold-off
				no_gaps = 1;
				squeeze_req <= 1'b1;
			end
			quota = items_sent + $urandom_range(40, 160);
			while (items_sent < quota) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					n = $urandom_range(1, 8);
				else if (r < 99)
					n = $urandom_range(9, 24);
				else
					n = $urandom_range(250, 270);
				send_box(n, $urandom_range(0, 3) == 0);
			end
			drain();
			no_gaps = 0;
			squeeze_req <= 1'b0;
			phase++;
		end

		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
design/dbd_pkg.sv
design/dbd_best.sv
design/dbd_corner.sv
design/detector_box_decode_core.sv
tb/box_decode_checker.sv
tb/tb_top.sv
